FILE: hw/rtl/ecd_pkg.sv
// ecd_pkg: widths, codes, payload types and small arithmetic helpers
// shared by the easter date pipeline stages. no dependencies.
package ecd_pkg;

    localparam int YEAR_W  = 14;
    localparam int KIND_W  = 2;
    localparam int MONTH_W = 3;
    localparam int DAY_W   = 5;

    localparam logic [YEAR_W-1:0] YEAR_MIN        = 14'd1;
    localparam logic [YEAR_W-1:0] YEAR_MAX        = 14'd9999;
    localparam logic [YEAR_W-1:0] GREGORIAN_START = 14'd1583;

    localparam logic [KIND_W-1:0] KIND_JULIAN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WESTERN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ORTHODOX = 2'd2;
    localparam logic [KIND_W-1:0] KIND_INVALID  = 2'd3;

    // reciprocal multipliers, exact for every 14-bit year
    localparam logic [12:0] RECIP_100    = 13'd5243;
    localparam int          RECIP_100_SH = 19;
    localparam logic [17:0] RECIP_19     = 18'd220753;
    localparam int          RECIP_19_SH  = 22;
    localparam logic [17:0] RECIP_7      = 18'd149797;
    localparam int          RECIP_7_SH   = 20;
    localparam logic [7:0]  RECIP_3      = 8'd171;
    localparam int          RECIP_3_SH   = 9;
    localparam logic [10:0] RECIP_30     = 11'd1093;
    localparam int          RECIP_30_SH  = 15;

    localparam logic [7:0] RECIP_7_SMALL = 8'd147;

    localparam logic [7:0] MONTH_LEN [4] = '{8'd31, 8'd30, 8'd31, 8'd30};

    typedef enum logic [1:0] {
        RULE_JULIAN   = 2'd0,
        RULE_WESTERN  = 2'd1,
        RULE_ORTHODOX = 2'd2
    } t_rule;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [KIND_W-1:0] kind;
    } t_req;

    typedef struct packed {
        logic       ok;
        t_rule      rule;
        logic [1:0] a4;
        logic [2:0] b7;
        logic [4:0] a19;
        logic [6:0] cent;
        logic [6:0] c100;
        logic [2:0] f;
        logic [6:0] shift;
    } t_div;

    typedef struct packed {
        logic               ok;
        t_rule              rule;
        logic [4:0]         a19;
        logic [6:0]         cent;
        logic [6:0]         c100;
        logic [4:0]         h;
        logic [MONTH_W-1:0] alt_mo;
        logic [DAY_W-1:0]   alt_dy;
    } t_epact;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               valid_res;
    } t_res;

    // remainder by seven, valid for v below 204
    function automatic logic [2:0] mod7(input logic [7:0] v);
        logic [15:0] p;
        logic [7:0]  q;
        logic [7:0]  r;
        p = 16'(v) * 16'(RECIP_7_SMALL);
        q = 8'(p[15:10]);
        r = v - q * 8'd7;
        return r[2:0];
    endfunction

    // julian epact (19c + 15) mod 30 for c = year mod 19
    function automatic logic [4:0] julian_epact(input logic [4:0] c);
        logic [4:0] r;
        case (c)
            5'd0:    r = 5'd15;
            5'd1:    r = 5'd4;
            5'd2:    r = 5'd23;
            5'd3:    r = 5'd12;
            5'd4:    r = 5'd1;
            5'd5:    r = 5'd20;
            5'd6:    r = 5'd9;
            5'd7:    r = 5'd28;
            5'd8:    r = 5'd17;
            5'd9:    r = 5'd6;
            5'd10:   r = 5'd25;
            5'd11:   r = 5'd14;
            5'd12:   r = 5'd3;
            5'd13:   r = 5'd22;
            5'd14:   r = 5'd11;
            5'd15:   r = 5'd0;
            5'd16:   r = 5'd19;
            5'd17:   r = 5'd8;
            5'd18:   r = 5'd27;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/easter_date_computus.sv
// easter_date_computus: top level of the easter date pipeline, stream ports
// around ecd_divide, ecd_epact and ecd_date. depends on ecd_pkg.
//
// usage
//   input stream: one word per year. tdata carries the year, tuser the
//   calendar kind (0 julian, 1 western, 2 orthodox, 3 flagged invalid).
//   output stream: one word per input word, in order. tdata carries the
//   month and day of easter, tuser the valid flag; an out of range year or
//   kind gives valid low with month and day zero.
//   eight register stages, each with its own valid bit: a new year can be
//   accepted in every cycle, so the sustained rate is one word per cycle
//   while the receiver keeps tready high.
//   the last stage is the output register.
//   a stage that holds a word takes a new one only when it is passed on, so
//   when the receiver drops tready the words pile up in the stages and
//   s_axis_tready falls once all eight are full; nothing is lost or repeated.
//   synchronous active-low reset empties every stage; no state survives
//   between words.
module easter_date_computus import ecd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [13:0] year, [15:14] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [2:0] month, [7:3] day
    output logic        o_m_axis_tuser    // [0] valid_res
);

    t_req   w_req;
    t_div   w_div;
    t_epact w_epact;
    t_res   w_res;
    logic   w_div_vld, w_div_rdy;
    logic   w_ep_vld, w_ep_rdy;

    assign w_req.year = i_s_axis_tdata[YEAR_W-1:0];
    assign w_req.kind = i_s_axis_tuser;

    ecd_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (w_req),
        .o_valid (w_div_vld),
        .i_ready (w_div_rdy),
        .o_data  (w_div)
    );

    ecd_epact u_epact (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_vld),
        .o_ready (w_div_rdy),
        .i_data  (w_div),
        .o_valid (w_ep_vld),
        .i_ready (w_ep_rdy),
        .o_data  (w_epact)
    );

    ecd_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ep_vld),
        .o_ready (w_ep_rdy),
        .i_data  (w_epact),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (w_res)
    );

    assign o_m_axis_tdata = {w_res.day, w_res.month};
    assign o_m_axis_tuser = w_res.valid_res;

endmodule

FILE: hw/rtl/ecd_divide.sv
// ecd_divide: first two pipeline stages, year split by reciprocal multiplies
// into remainders, century and century corrections. depends on ecd_pkg.
module ecd_divide import ecd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_div o_data
);

    typedef struct packed {
        logic              ok;
        t_rule             rule;
        logic [YEAR_W-1:0] year;
        logic [6:0]        q100;
        logic [9:0]        q19;
        logic [11:0]       q7;
    } t_s1;

    t_s1         n_s1, r_s1;
    t_div        n_s2, r_s2;
    logic [1:0]  r_vld;
    logic [1:0]  w_rdy;
    logic [26:0] w_p100;
    logic [31:0] w_p19;
    logic [31:0] w_p7;
    logic [6:0]  w_x;

    assign w_rdy[1] = !r_vld[1] || i_ready;
    assign w_rdy[0] = !r_vld[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];
    assign o_valid  = r_vld[1];
    assign o_data   = r_s2;

    always_comb begin
        w_p100 = 27'(i_data.year) * 27'(RECIP_100);
        w_p19  = 32'(i_data.year) * 32'(RECIP_19);
        w_p7   = 32'(i_data.year) * 32'(RECIP_7);
        n_s1.year = i_data.year;
        n_s1.q100 = w_p100[RECIP_100_SH +: 7];
        n_s1.q19  = w_p19[RECIP_19_SH +: 10];
        n_s1.q7   = w_p7[RECIP_7_SH +: 12];
        n_s1.ok   = (i_data.year >= YEAR_MIN) && (i_data.year <= YEAR_MAX)
                    && (i_data.kind != KIND_INVALID);
        if (i_data.kind == KIND_JULIAN || i_data.year < GREGORIAN_START) begin
            n_s1.rule = RULE_JULIAN;
        end else if (i_data.kind == KIND_WESTERN) begin
            n_s1.rule = RULE_WESTERN;
        end else begin
            n_s1.rule = RULE_ORTHODOX;
        end
    end

    always_comb begin
        n_s2.ok    = r_s1.ok;
        n_s2.rule  = r_s1.rule;
        n_s2.a4    = r_s1.year[1:0];
        n_s2.b7    = 3'(r_s1.year - 14'(r_s1.q7) * 14'd7);
        n_s2.a19   = 5'(r_s1.year - 14'(r_s1.q19) * 14'd19);
        n_s2.cent  = r_s1.q100;
        n_s2.c100  = 7'(r_s1.year - 14'(r_s1.q100) * 14'd100);
        n_s2.f     = 3'(r_s1.q100 >= 7'd17) + 3'(r_s1.q100 >= 7'd42)
                     + 3'(r_s1.q100 >= 7'd67) + 3'(r_s1.q100 >= 7'd92);
        w_x        = r_s1.q100 - 7'd16;
        n_s2.shift = (r_s1.q100 >= 7'd16) ? 7'd10 + w_x - {2'b00, w_x[6:2]} : 7'd10;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            if (w_rdy[1]) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_s1 <= n_s1;
        end
        if (w_rdy[1] && r_vld[0]) begin
            r_s2 <= n_s2;
        end
    end

    a_rem_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && r_s2.ok) |-> (r_s2.a19 < 5'd19 && r_s2.b7 != 3'd7))
        else $error("ecd_divide: remainder by 19 or 7 out of range");

    a_rem_cent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && r_s2.ok) |-> (r_s2.c100 < 7'd100 && r_s2.cent < 7'd100))
        else $error("ecd_divide: century split out of range");

    a_rule_cent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && r_s2.ok && r_s2.rule != RULE_JULIAN) |-> (r_s2.cent >= 7'd15))
        else $error("ecd_divide: gregorian rule before 1583");

endmodule

FILE: hw/rtl/ecd_epact.sv
// ecd_epact: stages three to five, julian full moon and sunday, gregorian
// epact and the julian or orthodox date. depends on ecd_pkg.
module ecd_epact import ecd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_div   i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_epact o_data
);

    typedef struct packed {
        logic       ok;
        t_rule      rule;
        logic [1:0] a4;
        logic [2:0] b7;
        logic [4:0] a19;
        logic [6:0] cent;
        logic [6:0] c100;
        logic [6:0] shift;
        logic [4:0] dj;
        logic [5:0] g;
    } t_s3;

    typedef struct packed {
        logic       ok;
        t_rule      rule;
        logic [4:0] a19;
        logic [6:0] cent;
        logic [6:0] c100;
        logic [6:0] shift;
        logic [5:0] tj;
        logic [9:0] hv;
    } t_s4;

    t_s3                n_s3, r_s3;
    t_s4                n_s4, r_s4;
    t_epact             n_s5, r_s5;
    logic [2:0]         r_vld;
    logic [2:0]         w_rdy;
    logic [7:0]         w_gx;
    logic [15:0]        w_gp;
    logic [7:0]         w_ev;
    logic [20:0]        w_hp;
    logic [7:0]         w_ot;
    logic [MONTH_W-1:0] w_om;
    logic               w_stop;

    assign w_rdy[2] = !r_vld[2] || i_ready;
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];
    assign w_rdy[0] = !r_vld[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];
    assign o_valid  = r_vld[2];
    assign o_data   = r_s5;

    always_comb begin
        n_s3.ok    = i_data.ok;
        n_s3.rule  = i_data.rule;
        n_s3.a4    = i_data.a4;
        n_s3.b7    = i_data.b7;
        n_s3.a19   = i_data.a19;
        n_s3.cent  = i_data.cent;
        n_s3.c100  = i_data.c100;
        n_s3.shift = i_data.shift;
        n_s3.dj    = julian_epact(i_data.a19);
        w_gx       = 8'(i_data.cent) - 8'(i_data.f) + 8'd1;
        w_gp       = 16'(w_gx) * 16'(RECIP_3);
        n_s3.g     = w_gp[RECIP_3_SH +: 6];
    end

    always_comb begin
        n_s4.ok    = r_s3.ok;
        n_s4.rule  = r_s3.rule;
        n_s4.a19   = r_s3.a19;
        n_s4.cent  = r_s3.cent;
        n_s4.c100  = r_s3.c100;
        n_s4.shift = r_s3.shift;
        w_ev       = 8'd34 + 8'({r_s3.a4, 1'b0}) + 8'({r_s3.b7, 2'b00}) - 8'(r_s3.dj);
        n_s4.tj    = 6'(r_s3.dj) + 6'(mod7(w_ev)) + 6'd22;
        n_s4.hv    = 10'(r_s3.a19) * 10'd19 + 10'(r_s3.cent) + 10'd135
                     - 10'(r_s3.cent[6:2]) - 10'(r_s3.g);
    end

    always_comb begin
        n_s5.ok   = r_s4.ok;
        n_s5.rule = r_s4.rule;
        n_s5.a19  = r_s4.a19;
        n_s5.cent = r_s4.cent;
        n_s5.c100 = r_s4.c100;
        w_hp      = 21'(r_s4.hv) * 21'(RECIP_30);
        n_s5.h    = 5'(r_s4.hv - 10'(w_hp[RECIP_30_SH +: 5]) * 10'd30);
        // orthodox: walk the shifted day count through the month lengths
        w_ot   = 8'(r_s4.tj) + 8'(r_s4.shift);
        w_om   = 3'd3;
        w_stop = 1'b0;
        for (int j = 0; j < 4; j++) begin
            if (!w_stop && w_ot > MONTH_LEN[j]) begin
                w_ot = w_ot - MONTH_LEN[j];
                w_om = w_om + 3'd1;
            end else begin
                w_stop = 1'b1;
            end
        end
        if (r_s4.rule == RULE_ORTHODOX) begin
            n_s5.alt_mo = w_om;
            n_s5.alt_dy = w_ot[DAY_W-1:0];
        end else if (r_s4.tj > 6'd31) begin
            n_s5.alt_mo = 3'd4;
            n_s5.alt_dy = 5'(r_s4.tj - 6'd31);
        end else begin
            n_s5.alt_mo = 3'd3;
            n_s5.alt_dy = r_s4.tj[DAY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            if (w_rdy[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (w_rdy[2]) begin
                r_vld[2] <= r_vld[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_s3 <= n_s3;
        end
        if (w_rdy[1] && r_vld[0]) begin
            r_s4 <= n_s4;
        end
        if (w_rdy[2] && r_vld[1]) begin
            r_s5 <= n_s5;
        end
    end

endmodule

FILE: hw/rtl/ecd_date.sv
// ecd_date: stages six to eight, gregorian weekday term and correction,
// final month and day selection into the output register. depends on ecd_pkg.
module ecd_date import ecd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_epact i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_res   o_data
);

    typedef struct packed {
        logic               ok;
        t_rule              rule;
        logic [4:0]         a19;
        logic [4:0]         h;
        logic [2:0]         l;
        logic [MONTH_W-1:0] alt_mo;
        logic [DAY_W-1:0]   alt_dy;
    } t_s6;

    typedef struct packed {
        logic               ok;
        t_rule              rule;
        logic [7:0]         s;
        logic [MONTH_W-1:0] alt_mo;
        logic [DAY_W-1:0]   alt_dy;
    } t_s7;

    t_s6        n_s6, r_s6;
    t_s7        n_s7, r_s7;
    t_res       n_s8, r_s8;
    logic [2:0] r_vld;
    logic [2:0] w_rdy;
    logic [7:0] w_lv;
    logic [9:0] w_mv;

    assign w_rdy[2] = !r_vld[2] || i_ready;
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];
    assign w_rdy[0] = !r_vld[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];
    assign o_valid  = r_vld[2];
    assign o_data   = r_s8;

    always_comb begin
        n_s6.ok     = i_data.ok;
        n_s6.rule   = i_data.rule;
        n_s6.a19    = i_data.a19;
        n_s6.h      = i_data.h;
        n_s6.alt_mo = i_data.alt_mo;
        n_s6.alt_dy = i_data.alt_dy;
        w_lv        = 8'd67 + 8'({i_data.cent[1:0], 1'b0}) + 8'({i_data.c100[6:2], 1'b0})
                      - 8'(i_data.h) - 8'(i_data.c100[1:0]);
        n_s6.l      = mod7(w_lv);
    end

    always_comb begin
        n_s7.ok     = r_s6.ok;
        n_s7.rule   = r_s6.rule;
        n_s7.alt_mo = r_s6.alt_mo;
        n_s7.alt_dy = r_s6.alt_dy;
        w_mv        = 10'(r_s6.a19) + 10'(r_s6.h) * 10'd11 + 10'(r_s6.l) * 10'd22;
        n_s7.s      = 8'(r_s6.h) + 8'(r_s6.l) + 8'd114 - ((w_mv >= 10'd451) ? 8'd7 : 8'd0);
    end

    always_comb begin
        n_s8.valid_res = r_s7.ok;
        if (!r_s7.ok) begin
            n_s8.month = '0;
            n_s8.day   = '0;
        end else if (r_s7.rule == RULE_WESTERN) begin
            if (r_s7.s >= 8'd124) begin
                n_s8.month = 3'd4;
                n_s8.day   = 5'(r_s7.s - 8'd123);
            end else begin
                n_s8.month = 3'd3;
                n_s8.day   = 5'(r_s7.s - 8'd92);
            end
        end else begin
            n_s8.month = r_s7.alt_mo;
            n_s8.day   = r_s7.alt_dy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            if (w_rdy[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (w_rdy[2]) begin
                r_vld[2] <= r_vld[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_s6 <= n_s6;
        end
        if (w_rdy[1] && r_vld[0]) begin
            r_s7 <= n_s7;
        end
        if (w_rdy[2] && r_vld[1]) begin
            r_s8 <= n_s8;
        end
    end

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && r_s8.valid_res) |->
            (r_s8.month >= 3'd3 && r_s8.day != 5'd0))
        else $error("ecd_date: valid result with impossible date");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !r_s8.valid_res) |-> (r_s8.month == 3'd0 && r_s8.day == 5'd0))
        else $error("ecd_date: invalid result not cleared");

    a_western_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && r_s7.ok && r_s7.rule == RULE_WESTERN) |->
            (r_s7.s >= 8'd107 && r_s7.s <= 8'd149))
        else $error("ecd_date: gregorian day count outside march and april");

endmodule
